FILE: sv/two_level_page_table_manager_macros.svh
// assertion macros shared by the page table manager checkers
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH

// same-cycle implication, off during reset
`define TLPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page table manager check failed");

// next-cycle implication, off during reset
`define TLPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page table manager check failed");

`endif

FILE: sv/tlpt_pkg.sv
// shared types, constants and helpers of the page table manager
package tlpt_pkg;

   localparam int NUM_FRAMES   = 16;
   localparam int FRAME_BITS   = $clog2(NUM_FRAMES);
   localparam int NF_BITS      = $clog2(NUM_FRAMES + 1);
   localparam int INDEX_BITS   = 10;
   localparam int PAGE_BITS    = 20;
   localparam int ENTRY_BITS   = PAGE_BITS + 1;
   localparam int NEW_BITS     = 4;
   localparam int ADDR_BITS    = FRAME_BITS + INDEX_BITS;
   localparam int STORE_DEPTH  = NUM_FRAMES * (1 << INDEX_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // reciprocal for the frame modulo of a 20-bit page field
   localparam logic [PAGE_BITS-1:0] MOD_RECIP = PAGE_BITS'((1 << PAGE_BITS) / NUM_FRAMES);
   localparam int SMALL_BITS = (NF_BITS > NEW_BITS) ? NF_BITS : NEW_BITS;
   localparam int MOD_STEPS  = (1 << NEW_BITS) / NUM_FRAMES;

   localparam logic CSR_ROOT_FRAME = 1'b0;

   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT_RD,
      ST_ROOT_WAIT,
      ST_ROOT_MOD,
      ST_ROOT_WR,
      ST_LEAF_WR,
      ST_LEAF_RD,
      ST_LEAF_WAIT,
      ST_LEAF_CLR,
      ST_SCAN,
      ST_SCAN_END,
      ST_ROOT_FREE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      ADDR_CLEAR,
      ADDR_ROOT,
      ADDR_LEAF,
      ADDR_SCAN
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_ZERO,
      WD_NEW_FRAME,
      WD_PAGE
   } wdata_sel_type;

   typedef struct packed {
      logic          accept;
      logic          mem_rd;
      logic          mem_we;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          root_latch;
      logic          sub_from_root;
      logic          sub_from_new;
      logic          leaf_latch;
      logic          clr_inc;
      logic          scan_start;
      logic          scan_inc;
      logic          set_consumed;
      logic          set_freed;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic unmap;
      logic root_valid;
      logic clr_last;
      logic scan_last;
      logic scan_hit;
      logic rsp_free;
   } status_type;

   // frame number of a 4-bit field, reduced modulo the frame count
   function automatic logic [FRAME_BITS-1:0] frame_mod_small(input logic [NEW_BITS-1:0] x);
      logic [SMALL_BITS-1:0] v;
      v = SMALL_BITS'(x);
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (v >= SMALL_BITS'(NUM_FRAMES)) begin
            v = v - SMALL_BITS'(NUM_FRAMES);
         end
      end
      return v[FRAME_BITS-1:0];
   endfunction

endpackage

FILE: sv/tlpt_ctrl.sv
// sequencer of the table walk, update, unmap scan and reset clear
module tlpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tlpt_pkg::status_type status,
   output tlpt_pkg::cmd_type    cmd,
   output logic                 req_ready
);

   tlpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tlpt_pkg::ST_CLEAR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = tlpt_pkg::ADDR_CLEAR;
            cmd.wdata_sel = tlpt_pkg::WD_ZERO;
            cmd.clr_inc   = 1'b1;
            if (status.clr_last) begin
               state_in = tlpt_pkg::ST_IDLE;
            end
         end
         tlpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = tlpt_pkg::ST_ROOT_RD;
            end
         end
         tlpt_pkg::ST_ROOT_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = tlpt_pkg::ADDR_ROOT;
            state_in     = tlpt_pkg::ST_ROOT_WAIT;
         end
         tlpt_pkg::ST_ROOT_WAIT: begin
            cmd.root_latch = 1'b1;
            state_in       = tlpt_pkg::ST_ROOT_MOD;
         end
         tlpt_pkg::ST_ROOT_MOD: begin
            cmd.sub_from_root = 1'b1;
            if (status.op == tlpt_pkg::OP_QUERY) begin
               state_in = status.root_valid ? tlpt_pkg::ST_LEAF_RD : tlpt_pkg::ST_RESP;
            end else if (status.unmap) begin
               state_in = status.root_valid ? tlpt_pkg::ST_LEAF_CLR : tlpt_pkg::ST_RESP;
            end else begin
               state_in = status.root_valid ? tlpt_pkg::ST_LEAF_WR : tlpt_pkg::ST_ROOT_WR;
            end
         end
         tlpt_pkg::ST_ROOT_WR: begin
            // install the fresh frame as subtable
            cmd.mem_we       = 1'b1;
            cmd.addr_sel     = tlpt_pkg::ADDR_ROOT;
            cmd.wdata_sel    = tlpt_pkg::WD_NEW_FRAME;
            cmd.sub_from_new = 1'b1;
            cmd.set_consumed = 1'b1;
            state_in         = tlpt_pkg::ST_LEAF_WR;
         end
         tlpt_pkg::ST_LEAF_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = tlpt_pkg::ADDR_LEAF;
            cmd.wdata_sel = tlpt_pkg::WD_PAGE;
            state_in      = tlpt_pkg::ST_RESP;
         end
         tlpt_pkg::ST_LEAF_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = tlpt_pkg::ADDR_LEAF;
            state_in     = tlpt_pkg::ST_LEAF_WAIT;
         end
         tlpt_pkg::ST_LEAF_WAIT: begin
            cmd.leaf_latch = 1'b1;
            state_in       = tlpt_pkg::ST_RESP;
         end
         tlpt_pkg::ST_LEAF_CLR: begin
            cmd.mem_we     = 1'b1;
            cmd.addr_sel   = tlpt_pkg::ADDR_LEAF;
            cmd.wdata_sel  = tlpt_pkg::WD_ZERO;
            cmd.scan_start = 1'b1;
            state_in       = tlpt_pkg::ST_SCAN;
         end
         tlpt_pkg::ST_SCAN: begin
            // read one entry a cycle, check the one read in the cycle before
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = tlpt_pkg::ADDR_SCAN;
            cmd.scan_inc = 1'b1;
            if (status.scan_hit) begin
               state_in = tlpt_pkg::ST_RESP;
            end else if (status.scan_last) begin
               state_in = tlpt_pkg::ST_SCAN_END;
            end
         end
         tlpt_pkg::ST_SCAN_END: begin
            state_in = status.scan_hit ? tlpt_pkg::ST_RESP : tlpt_pkg::ST_ROOT_FREE;
         end
         tlpt_pkg::ST_ROOT_FREE: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = tlpt_pkg::ADDR_ROOT;
            cmd.wdata_sel = tlpt_pkg::WD_ZERO;
            cmd.set_freed = 1'b1;
            state_in      = tlpt_pkg::ST_RESP;
         end
         tlpt_pkg::ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = tlpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlpt_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

FILE: sv/tlpt_dp.sv
// frame store, address and data selection, request and response registers
module tlpt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  tlpt_pkg::cmd_type                   cmd,
   output tlpt_pkg::status_type                status,
   input  logic [tlpt_pkg::NEW_BITS-1:0]       root_frame,
   input  logic                                req_op,
   input  logic [tlpt_pkg::PAGE_BITS-1:0]      req_virtual_page,
   input  logic [tlpt_pkg::PAGE_BITS-1:0]      req_phys_page,
   input  logic                                req_unmap,
   input  logic [tlpt_pkg::NEW_BITS-1:0]       req_new_frame,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_mapped,
   output logic [tlpt_pkg::PAGE_BITS-1:0]      rsp_phys_page_out,
   output logic                                rsp_frame_consumed,
   output logic                                rsp_table_freed
);

   localparam int PB = tlpt_pkg::PAGE_BITS;
   localparam int FB = tlpt_pkg::FRAME_BITS;
   localparam int IB = tlpt_pkg::INDEX_BITS;
   localparam int NB = tlpt_pkg::NF_BITS;
   localparam int AB = tlpt_pkg::ADDR_BITS;
   localparam int EB = tlpt_pkg::ENTRY_BITS;

   logic [EB-1:0] store [tlpt_pkg::STORE_DEPTH];
   logic [EB-1:0] rdata_ff;

   // request fields
   logic                            op_ff;
   logic                            unmap_ff;
   logic [IB-1:0]                   hi_ff;
   logic [IB-1:0]                   lo_ff;
   logic [PB-1:0]                   ppn_ff;
   logic [tlpt_pkg::NEW_BITS-1:0]   new_raw_ff;
   logic [FB-1:0]                   new_f_ff;
   logic [FB-1:0]                   root_f_ff;

   // walk registers
   logic [EB-1:0]   root_entry_ff;
   logic [2*PB-1:0] product_ff;
   logic [FB-1:0]   sub_f_ff;
   logic            mapped_ff;
   logic [PB-1:0]   page_ff;
   logic            consumed_ff;
   logic            freed_ff;

   // counters
   logic [AB-1:0] clr_cnt_ff;
   logic [IB-1:0] scan_cnt_ff;
   logic          chk_ff;

   // response register
   logic          rsp_valid_ff;
   logic          rsp_mapped_ff;
   logic [PB-1:0] rsp_page_ff;
   logic          rsp_consumed_ff;
   logic          rsp_freed_ff;

   logic [AB-1:0]    addr;
   logic [EB-1:0]    wdata;
   logic [PB-1:0]    quot;
   logic [PB+NB-1:0] quot_n;
   logic [PB+NB-1:0] rem_w;
   logic [NB:0]      rem;
   logic [FB-1:0]    sub_mod;

   always_comb begin
      case (cmd.addr_sel)
         tlpt_pkg::ADDR_CLEAR: addr = clr_cnt_ff;
         tlpt_pkg::ADDR_ROOT:  addr = {root_f_ff, hi_ff};
         tlpt_pkg::ADDR_LEAF:  addr = {sub_f_ff, lo_ff};
         tlpt_pkg::ADDR_SCAN:  addr = {sub_f_ff, scan_cnt_ff};
         default:              addr = clr_cnt_ff;
      endcase
   end

   always_comb begin
      case (cmd.wdata_sel)
         tlpt_pkg::WD_ZERO:      wdata = '0;
         tlpt_pkg::WD_NEW_FRAME: wdata = {PB'(new_raw_ff), 1'b1};
         tlpt_pkg::WD_PAGE:      wdata = {ppn_ff, 1'b1};
         default:                wdata = '0;
      endcase
   end

   // page field modulo frame count: reciprocal estimate, one correction
   always_comb begin
      quot   = product_ff[2*PB-1:PB];
      quot_n = (PB+NB)'(quot) * (PB+NB)'(tlpt_pkg::NUM_FRAMES);
      rem_w  = (PB+NB)'(root_entry_ff[EB-1:1]) - quot_n;
      rem    = rem_w[NB:0];
      if (rem >= (NB+1)'(tlpt_pkg::NUM_FRAMES)) begin
         rem = rem - (NB+1)'(tlpt_pkg::NUM_FRAMES);
      end
      sub_mod = rem[FB-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         store[addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= store[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_op;
         unmap_ff    <= req_unmap;
         hi_ff       <= req_virtual_page[2*IB-1:IB];
         lo_ff       <= req_virtual_page[IB-1:0];
         ppn_ff      <= req_phys_page;
         new_raw_ff  <= req_new_frame;
         new_f_ff    <= tlpt_pkg::frame_mod_small(req_new_frame);
         root_f_ff   <= tlpt_pkg::frame_mod_small(root_frame);
      end
      if (cmd.root_latch) begin
         root_entry_ff <= rdata_ff;
         product_ff    <= (2*PB)'(rdata_ff[EB-1:1]) * (2*PB)'(tlpt_pkg::MOD_RECIP);
      end
      if (cmd.sub_from_new) begin
         sub_f_ff <= new_f_ff;
      end else if (cmd.sub_from_root) begin
         sub_f_ff <= sub_mod;
      end
      if (cmd.accept) begin
         mapped_ff   <= 1'b0;
         page_ff     <= '0;
         consumed_ff <= 1'b0;
         freed_ff    <= 1'b0;
      end else begin
         if (cmd.leaf_latch) begin
            mapped_ff <= rdata_ff[0];
            page_ff   <= rdata_ff[0] ? rdata_ff[EB-1:1] : '0;
         end
         if (cmd.set_consumed) begin
            consumed_ff <= 1'b1;
         end
         if (cmd.set_freed) begin
            freed_ff <= 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         rsp_mapped_ff   <= mapped_ff;
         rsp_page_ff     <= page_ff;
         rsp_consumed_ff <= consumed_ff;
         rsp_freed_ff    <= freed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         scan_cnt_ff  <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_inc) begin
            clr_cnt_ff <= (clr_cnt_ff == AB'(tlpt_pkg::STORE_DEPTH - 1)) ? '0 : clr_cnt_ff + 1'b1;
         end
         if (cmd.scan_start) begin
            scan_cnt_ff <= '0;
         end else if (cmd.scan_inc) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         chk_ff <= cmd.scan_inc;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.op         = op_ff;
      status.unmap      = unmap_ff;
      status.root_valid = root_entry_ff[0];
      status.clr_last   = (clr_cnt_ff == AB'(tlpt_pkg::STORE_DEPTH - 1));
      status.scan_last  = (scan_cnt_ff == '1);
      status.scan_hit   = chk_ff && (rdata_ff != '0);
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mapped         = rsp_mapped_ff;
   assign rsp_phys_page_out  = rsp_page_ff;
   assign rsp_frame_consumed = rsp_consumed_ff;
   assign rsp_table_freed    = rsp_freed_ff;

endmodule

FILE: sv/two_level_page_table_manager.sv
// top level of the two-level page table manager
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  op, virtual_page, phys_page, unmap, new_frame
//   rsp       out         rsp_valid/rsp_stall  mapped, phys_page_out, frame_consumed, table_freed
//   csr       in/out      psel/penable/pready  root_frame at byte address 0
//
// one request at a time through a single-port frame store with registered read:
// a query reads the root entry, then the leaf if a subtable exists; an update first installs
// the request frame as subtable if none exists, then writes the leaf; an unmap with a subtable
// scans up to its 1024 entries. after reset a clearing pass writes all NUM_FRAMES*1024 entries
// with req_stall high; csr writes are taken meanwhile.
// a stalled response holds; the next request is accepted while it waits.
module two_level_page_table_manager (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_op,
   input  logic [tlpt_pkg::PAGE_BITS-1:0]          req_virtual_page,
   input  logic [tlpt_pkg::PAGE_BITS-1:0]          req_phys_page,
   input  logic                                    req_unmap,
   input  logic [tlpt_pkg::NEW_BITS-1:0]           req_new_frame,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_mapped,
   output logic [tlpt_pkg::PAGE_BITS-1:0]          rsp_phys_page_out,
   output logic                                    rsp_frame_consumed,
   output logic                                    rsp_table_freed,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [tlpt_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  logic [tlpt_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [tlpt_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                    pready
);

   tlpt_pkg::cmd_type    cmd;
   tlpt_pkg::status_type status;
   logic                 req_ready;
   logic [tlpt_pkg::NEW_BITS-1:0] root_frame_ff;
   logic                 csr_index;

   assign csr_index = paddr[tlpt_pkg::CSR_ADDR_BITS-1];
   assign pready    = 1'b1;
   assign req_stall = !req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
      end else if (psel && penable && pwrite && pready
                   && csr_index == tlpt_pkg::CSR_ROOT_FRAME) begin
         root_frame_ff <= pwdata[tlpt_pkg::NEW_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == tlpt_pkg::CSR_ROOT_FRAME) begin
         prdata = tlpt_pkg::CSR_DATA_BITS'(root_frame_ff);
      end
   end

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   tlpt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .root_frame         (root_frame_ff),
      .req_op             (req_op),
      .req_virtual_page   (req_virtual_page),
      .req_phys_page      (req_phys_page),
      .req_unmap          (req_unmap),
      .req_new_frame      (req_new_frame),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_mapped         (rsp_mapped),
      .rsp_phys_page_out  (rsp_phys_page_out),
      .rsp_frame_consumed (rsp_frame_consumed),
      .rsp_table_freed    (rsp_table_freed)
   );

endmodule

FILE: sv/tlpt_checker.sv
// port-level checks of the page table manager, bound to the top level
`include "two_level_page_table_manager_macros.svh"

module tlpt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_mapped,
   input logic [tlpt_pkg::PAGE_BITS-1:0]      rsp_phys_page_out,
   input logic                                rsp_frame_consumed,
   input logic                                rsp_table_freed
);

   // a stalled response stays offered
   `TLPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // one request in flight: stall rises right after an accept
   `TLPT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a response reports at most one kind of outcome
   `TLPT_ASSERT_NOW(a_one_outcome, clock, reset, rsp_valid,
      $countones({rsp_mapped, rsp_frame_consumed, rsp_table_freed}) <= 1)

   // no page is reported without a mapping
   `TLPT_ASSERT_NOW(a_page_zero, clock, reset, rsp_valid && !rsp_mapped,
      rsp_phys_page_out == '0)

endmodule

bind two_level_page_table_manager tlpt_checker u_checker (.*);

FILE: dv/testbench.sv
// testbench for the two-level page table manager: shadow page table walk plus response checks
`timescale 1ns / 1ps

module testbench;

   localparam int PAGE_BITS     = tlpt_pkg::PAGE_BITS;
   localparam int NEW_BITS      = tlpt_pkg::NEW_BITS;
   localparam int ENTRY_BITS    = tlpt_pkg::ENTRY_BITS;
   localparam int INDEX_BITS    = tlpt_pkg::INDEX_BITS;
   localparam int STORE_DEPTH   = tlpt_pkg::STORE_DEPTH;
   localparam int NUM_FRAMES    = tlpt_pkg::NUM_FRAMES;
   localparam int CSR_ADDR_BITS = tlpt_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = tlpt_pkg::CSR_DATA_BITS;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int DRAIN_CYCLES = 1100;
   localparam logic [CSR_ADDR_BITS-1:0] ROOT_FRAME_ADDR =
      CSR_ADDR_BITS'(4 * tlpt_pkg::CSR_ROOT_FRAME);

   typedef struct packed {
      logic                 op;
      logic [PAGE_BITS-1:0] virtual_page;
      logic [PAGE_BITS-1:0] phys_page;
      logic                 unmap;
      logic [NEW_BITS-1:0]  new_frame;
   } request_type;

   typedef struct packed {
      logic                 mapped;
      logic [PAGE_BITS-1:0] phys_page_out;
      logic                 frame_consumed;
      logic                 table_freed;
   } translation_type;

   class translation_tracker;
      bit [ENTRY_BITS-1:0] shadow_store [STORE_DEPTH];
      bit [3:0]            root_frame;
      translation_type     expected_walks[$];
      int errors, n_query, n_update, n_unmap, n_hit, n_installed, n_freed, n_settings;

      function int unsigned slot_of(bit [PAGE_BITS-1:0] frame, bit [INDEX_BITS-1:0] idx);
         return (int'(frame) % NUM_FRAMES) * (1 << INDEX_BITS) + int'(idx);
      endfunction

      function bit subtable_empty(bit [PAGE_BITS-1:0] frame);
         for (int i = 0; i < (1 << INDEX_BITS); i++) begin
            if (shadow_store[slot_of(frame, INDEX_BITS'(i))] != '0) return 0;
         end
         return 1;
      endfunction

      function void set_root_frame(bit [3:0] value);
         root_frame = value;
         n_settings++;
      endfunction

      function int pending();
         return expected_walks.size();
      endfunction

      function void apply_request(request_type r);
         int unsigned          root_slot;
         bit [ENTRY_BITS-1:0]  root_entry, leaf;
         bit [PAGE_BITS-1:0]   sub_frame;
         bit [INDEX_BITS-1:0]  lo;
         translation_type      t;
         t = '0;
         lo = r.virtual_page[INDEX_BITS-1:0];
         root_slot = slot_of(PAGE_BITS'(root_frame),
                             r.virtual_page[PAGE_BITS-1:INDEX_BITS]);
         root_entry = shadow_store[root_slot];
         if (r.op == tlpt_pkg::OP_QUERY) begin
            n_query++;
            if (root_entry[0]) begin
               leaf = shadow_store[slot_of(root_entry[ENTRY_BITS-1:1], lo)];
               if (leaf[0]) begin
                  t.mapped = 1'b1;
                  t.phys_page_out = leaf[ENTRY_BITS-1:1];
                  n_hit++;
               end
            end
         end else if (r.unmap) begin
            n_unmap++;
            if (root_entry[0]) begin
               sub_frame = root_entry[ENTRY_BITS-1:1];
               shadow_store[slot_of(sub_frame, lo)] = '0;
               if (subtable_empty(sub_frame)) begin
                  shadow_store[root_slot] = '0;
                  t.table_freed = 1'b1;
                  n_freed++;
               end
            end
         end else begin
            n_update++;
            // root entry goes first, so an aliased frame sees both writes in that order
            if (!root_entry[0]) begin
               sub_frame = PAGE_BITS'(r.new_frame);
               shadow_store[root_slot] = {sub_frame, 1'b1};
               t.frame_consumed = 1'b1;
               n_installed++;
            end else begin
               sub_frame = root_entry[ENTRY_BITS-1:1];
            end
            shadow_store[slot_of(sub_frame, lo)] = {r.phys_page, 1'b1};
         end
         expected_walks.push_back(t);
      endfunction

      function void compare_response(translation_type got);
         translation_type want;
         if (expected_walks.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = expected_walks.pop_front();
         if (got.mapped !== want.mapped) begin
            $error("mapped: expected %0d, actual %0d", want.mapped, got.mapped);
            errors++;
         end
         if (got.phys_page_out !== want.phys_page_out) begin
            $error("phys_page_out: expected 0x%05h, actual 0x%05h",
                   want.phys_page_out, got.phys_page_out);
            errors++;
         end
         if (got.frame_consumed !== want.frame_consumed) begin
            $error("frame_consumed: expected %0d, actual %0d",
                   want.frame_consumed, got.frame_consumed);
            errors++;
         end
         if (got.table_freed !== want.table_freed) begin
            $error("table_freed: expected %0d, actual %0d", want.table_freed, got.table_freed);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_op;
   logic [PAGE_BITS-1:0]     req_virtual_page;
   logic [PAGE_BITS-1:0]     req_phys_page;
   logic                     req_unmap;
   logic [NEW_BITS-1:0]      req_new_frame;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_mapped;
   logic [PAGE_BITS-1:0]     rsp_phys_page_out;
   logic                     rsp_frame_consumed;
   logic                     rsp_table_freed;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   translation_tracker walks;
   int req_idle_pct = 31;
   int rsp_stall_pct = 31;
   int quiet_cycles = 0;

   two_level_page_table_manager dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_virtual_page(req_virtual_page),
      .req_phys_page(req_phys_page),
      .req_unmap(req_unmap),
      .req_new_frame(req_new_frame),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_mapped(rsp_mapped),
      .rsp_phys_page_out(rsp_phys_page_out),
      .rsp_frame_consumed(rsp_frame_consumed),
      .rsp_table_freed(rsp_table_freed),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin : monitor
      bit busy;
      busy = 0;
      if (!reset) begin
         if (psel && penable && pwrite && pready && paddr == ROOT_FRAME_ADDR) begin
            walks.set_root_frame(4'(pwdata));
         end
         if (req_valid && !req_stall) begin
            walks.apply_request({req_op, req_virtual_page, req_phys_page, req_unmap,
                                 req_new_frame});
            busy = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            walks.compare_response({rsp_mapped, rsp_phys_page_out, rsp_frame_consumed,
                                    rsp_table_freed});
            busy = 1;
         end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic write_root_frame(input bit [3:0] value);
      bit done;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ROOT_FRAME_ADDR;
      pwdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         done = pready;
         @(posedge clock);
      end while (!done);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_request(input request_type r);
      bit taken;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_virtual_page <= r.virtual_page;
      req_phys_page <= r.phys_page;
      req_unmap <= r.unmap;
      req_new_frame <= r.new_frame;
      // stall is sampled mid-cycle so the edge decision is race free
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send(input logic op, input logic [PAGE_BITS-1:0] vpn,
                       input logic [PAGE_BITS-1:0] ppn, input logic rm,
                       input logic [NEW_BITS-1:0] nf);
      send_request({op, vpn, ppn, rm, nf});
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (walks.pending() != 0);
   endtask

   initial begin
      request_type         r;
      bit [INDEX_BITS-1:0] hot_hi [4];
      bit [INDEX_BITS-1:0] hot_lo [3];
      bit [3:0]            setting;
      int                  pick;
      walks = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= tlpt_pkg::OP_QUERY;
      req_virtual_page <= '0;
      req_phys_page <= '0;
      req_unmap <= 1'b0;
      req_new_frame <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // root table in the top frame, taken while the store is being cleared
      write_root_frame(4'hF);
      send(tlpt_pkg::OP_QUERY,  20'h00000, 20'h00000, 1'b0, 4'h0);   // empty store
      send(tlpt_pkg::OP_UPDATE, 20'h00000, 20'h00000, 1'b1, 4'h0);   // unmap with no subtable
      send(tlpt_pkg::OP_UPDATE, 20'hFFFFF, 20'hFFFFF, 1'b0, 4'hF);   // new frame aliases root
      send(tlpt_pkg::OP_QUERY,  20'hFFFFF, 20'h00000, 1'b1, 4'hA);
      send(tlpt_pkg::OP_UPDATE, 20'h00000, 20'h00000, 1'b0, 4'h1);
      send(tlpt_pkg::OP_QUERY,  20'h00000, 20'hFFFFF, 1'b0, 4'hF);
      send(tlpt_pkg::OP_UPDATE, 20'h003FF, 20'hABCDE, 1'b0, 4'h2);   // subtable already there
      send(tlpt_pkg::OP_UPDATE, 20'h00000, 20'h00000, 1'b1, 4'h0);   // not empty yet
      send(tlpt_pkg::OP_UPDATE, 20'h003FF, 20'h00000, 1'b1, 4'h0);   // last leaf gone, frees
      send(tlpt_pkg::OP_QUERY,  20'h003FF, 20'h00000, 1'b0, 4'h0);
      send(tlpt_pkg::OP_UPDATE, 20'h00400, 20'h12345, 1'b0, 4'h7);
      send(tlpt_pkg::OP_UPDATE, 20'h00401, 20'h00000, 1'b1, 4'h0);   // absent leaf, scan runs
      send(tlpt_pkg::OP_UPDATE, 20'h00400, 20'h00000, 1'b1, 4'h0);
      // subtable in the root frame: the leaf write becomes a root entry with a wide frame
      send(tlpt_pkg::OP_UPDATE, 20'h00800, 20'h55555, 1'b0, 4'hF);
      send(tlpt_pkg::OP_QUERY,  20'h00BFF, 20'h00000, 1'b0, 4'h0);
      send(tlpt_pkg::OP_QUERY,  20'h00000, 20'h00000, 1'b0, 4'h0);
      send(tlpt_pkg::OP_UPDATE, 20'h00005, 20'hFFFF3, 1'b0, 4'h9);
      send(tlpt_pkg::OP_QUERY,  20'h00005, 20'h00000, 1'b0, 4'h0);
      // stale frame: install a frame that already holds a leaf
      send(tlpt_pkg::OP_UPDATE, 20'h00C01, 20'h00001, 1'b0, 4'h5);
      send(tlpt_pkg::OP_QUERY,  20'h00C05, 20'h00000, 1'b0, 4'h0);
      send(tlpt_pkg::OP_UPDATE, 20'h00800, 20'h00000, 1'b1, 4'h0);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: setting = 4'h0;
            1: setting = 4'hF;
            default: setting = 4'($urandom_range(15));
         endcase
         write_root_frame(setting);
         foreach (hot_hi[i]) hot_hi[i] = INDEX_BITS'($urandom);
         foreach (hot_lo[i]) hot_lo[i] = INDEX_BITS'($urandom);
         for (int n = 0; n < 200; n++) begin
            if (ph == 1 && n >= 40 && n < 140) begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end else begin
               req_idle_pct = 31;
               rsp_stall_pct = 31;
            end
            if ($urandom_range(49) == 0) wait_drained();
            pick = $urandom_range(99);
            r.op = (pick < 35) ? tlpt_pkg::OP_QUERY : tlpt_pkg::OP_UPDATE;
            r.unmap = (pick < 35) ? 1'($urandom) : (pick >= 65);
            // a few hot indexes keep walks landing on live subtables
            if ($urandom_range(9) == 0) begin
               r.virtual_page = PAGE_BITS'($urandom);
            end else begin
               r.virtual_page = {hot_hi[$urandom_range(3)], hot_lo[$urandom_range(2)]};
            end
            r.phys_page = PAGE_BITS'($urandom);
            r.new_frame = NEW_BITS'($urandom);
            send_request(r);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d queries (%0d hits), %0d updates, %0d unmaps, %0d root frame writes",
               walks.n_query, walks.n_hit, walks.n_update, walks.n_unmap, walks.n_settings);
      $display("%0d subtables installed from the request frame, %0d freed by unmap",
               walks.n_installed, walks.n_freed);
      if (walks.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
